// ===== rtl/lcr_pkg.sv =====
`default_nettype none

package lcr_pkg;

  // stream payload widths
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 40;

  // configuration port
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_ADDR_W-1:0] REG_GAIN_SELECT = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_HALF_PERIOD = 1'd1;

  // request codes
  localparam logic [2:0] ACT_MEASURE     = 3'd1;
  localparam logic [2:0] ACT_TARE        = 3'd2;
  localparam logic [2:0] ACT_POWER_DOWN  = 3'd3;
  localparam logic [2:0] ACT_POWER_UP    = 3'd4;
  localparam logic [2:0] ACT_LOAD_OFFSET = 3'd5;

  // result status codes
  typedef logic [1:0] status_t;
  localparam status_t ST_IDLE   = 2'd0;
  localparam status_t ST_BUSY   = 2'd1;
  localparam status_t ST_DONE   = 2'd2;
  localparam status_t ST_REJECT = 2'd3;

  // gain selector codes
  localparam logic [1:0] GAIN_A64 = 2'd1;
  localparam logic [1:0] GAIN_B32 = 2'd2;

  localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

  // controller to datapath commands
  typedef struct packed {
    logic    load_req;
    logic    tare;
    logic    begin_conv;
    logic    tick_inc;
    logic    tick_clr;
    logic    shift_in;
    logic    pulse_inc;
    logic    accumulate;
    logic    set_pd;
    logic    clr_pd;
    logic    load_offset;
    logic    out_load;
    logic    div_start;
    logic    finish;
    logic    sck;
    status_t status;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic tick_end;
    logic last_pulse;
    logic last_read;
    logic powered_down;
    logic div_done;
  } stat_t;

endpackage

`default_nettype wire

// ===== rtl/lcr_div.sv =====
`default_nettype none

module lcr_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [7:0]  divisor,
  output logic             done,
  output logic [31:0]      quot
);

  logic        busy;
  logic        fix;
  logic        neg;
  logic [31:0] mag;
  logic [7:0]  rem;
  logic [4:0]  cnt;
  logic [8:0]  rem_sh;
  logic        ge;

  // one quotient bit per cycle, restoring form
  assign rem_sh = {rem, mag[31]};
  assign ge     = rem_sh >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      fix  <= 1'b0;
    end else if (start) begin
      neg  <= dividend[31];
      mag  <= dividend[31] ? (~dividend + 32'd1) : dividend;
      rem  <= '0;
      cnt  <= '0;
      busy <= 1'b1;
    end else if (busy) begin
      rem <= ge ? 8'(rem_sh - {1'b0, divisor}) : rem_sh[7:0];
      mag <= {mag[30:0], ge};
      cnt <= cnt + 5'd1;
      if (cnt == 5'd31) begin
        busy <= 1'b0;
        fix  <= 1'b1;
      end
    end else if (fix) begin
      // restore the sign, truncation toward zero
      quot <= neg ? (~mag + 32'd1) : mag;
      fix  <= 1'b0;
      done <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lcr_datapath.sv =====
`default_nettype none

module lcr_datapath #(
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [lcr_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [lcr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                            dout_level,
  input  wire logic [7:0]                      read_count,
  input  wire logic [31:0]                     offset_load,
  input  wire lcr_pkg::cmd_t                   cmd,
  output lcr_pkg::stat_t                       stat,
  output logic [lcr_pkg::OUT_DATA_W-1:0]       out_data
);

  import lcr_pkg::*;

  localparam int PW = $clog2(SAMPLE_BITS + 4);

  logic [1:0]             gain_select;
  logic [15:0]            half_period;
  logic [15:0]            tick_count;
  logic [PW-1:0]          pulse_index;
  logic [SAMPLE_BITS-1:0] shift_word;
  logic [31:0]            running_sum;
  logic [7:0]             reads_left;
  logic [7:0]             reads_total;
  logic [31:0]            offset_value;
  logic                   tare_pending;
  logic                   powered_down;

  logic [15:0]            hp;
  logic [15:0]            tick_next;
  logic [PW-1:0]          pulse_next;
  logic [PW-1:0]          pulse_total;
  logic [31:0]            word_ext;
  logic                   div_done;
  logic [31:0]            quot;
  logic signed [32:0]     diff;
  logic [31:0]            result;

  // timing and pulse count status
  always_comb begin
    hp        = (half_period == 16'd0) ? 16'd1 : half_period;
    tick_next = tick_count + 16'd1;
    pulse_next = pulse_index + PW'(1);
    if (gain_select == GAIN_A64) begin
      pulse_total = PW'(SAMPLE_BITS + 3);
    end else if (gain_select == GAIN_B32) begin
      pulse_total = PW'(SAMPLE_BITS + 2);
    end else begin
      pulse_total = PW'(SAMPLE_BITS + 1);
    end
    word_ext = 32'($signed(shift_word));
  end

  assign stat.tick_end     = (tick_next >= hp) || (tick_next == 16'd0);
  assign stat.last_pulse   = pulse_next >= pulse_total;
  assign stat.last_read    = reads_left == 8'd1;
  assign stat.powered_down = powered_down;
  assign stat.div_done     = div_done;

  // average of the summed words
  lcr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (running_sum),
    .divisor  (reads_total),
    .done     (div_done),
    .quot     (quot)
  );

  // average minus offset, saturated
  always_comb begin
    diff = $signed({quot[31], quot}) - $signed({offset_value[31], offset_value});
    if (diff[32] != diff[31]) begin
      result = diff[32] ? SAT_MIN : SAT_MAX;
    end else begin
      result = diff[31:0];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_select <= 2'd0;
      half_period <= 16'd1000;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_GAIN_SELECT: gain_select <= cfg_wdata[1:0];
        REG_HALF_PERIOD: half_period <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // transfer state
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count   <= '0;
      pulse_index  <= '0;
      shift_word   <= '0;
      running_sum  <= '0;
      reads_left   <= '0;
      reads_total  <= '0;
      offset_value <= '0;
      tare_pending <= 1'b0;
      powered_down <= 1'b0;
    end else begin
      if (cmd.load_req) begin
        reads_total  <= (read_count == 8'd0) ? 8'd1 : read_count;
        reads_left   <= (read_count == 8'd0) ? 8'd1 : read_count;
        running_sum  <= '0;
        tare_pending <= cmd.tare;
      end
      if (cmd.begin_conv) begin
        pulse_index <= '0;
        tick_count  <= '0;
        shift_word  <= '0;
      end
      if (cmd.tick_inc) begin
        tick_count <= tick_next;
      end
      if (cmd.tick_clr) begin
        tick_count <= '0;
      end
      if (cmd.shift_in && (pulse_index < PW'(SAMPLE_BITS))) begin
        shift_word <= {shift_word[SAMPLE_BITS-2:0], dout_level};
      end
      if (cmd.pulse_inc) begin
        pulse_index <= pulse_next;
      end
      if (cmd.accumulate) begin
        running_sum <= running_sum + word_ext;
        reads_left  <= reads_left - 8'd1;
      end
      if (cmd.set_pd) begin
        powered_down <= 1'b1;
      end
      if (cmd.clr_pd) begin
        powered_down <= 1'b0;
      end
      if (cmd.load_offset) begin
        offset_value <= offset_load;
      end
      if (cmd.finish && tare_pending) begin
        offset_value <= quot;
        tare_pending <= 1'b0;
      end
    end
  end

  // result register: sck, status, value from bit 0 up
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= {5'd0, 32'd0, cmd.status, cmd.sck};
    end else if (cmd.finish) begin
      out_data <= {5'd0, (tare_pending ? 32'd0 : result), ST_DONE, cmd.sck};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lcr_ctrl.sv =====
`default_nettype none

module lcr_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  wire logic           out_tready,
  input  wire logic [2:0]     action,
  input  wire logic           dout_level,
  input  wire lcr_pkg::stat_t stat,
  output lcr_pkg::cmd_t       cmd
);

  import lcr_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_WAIT,
    PH_HIGH,
    PH_LOW
  } phase_t;

  typedef enum logic [1:0] {
    HS_RUN,
    HS_DIV_START,
    HS_DIV_WAIT,
    HS_FINISH
  } hs_t;

  phase_t phase;
  phase_t phase_next;
  phase_t adv_phase;
  hs_t    hs;
  logic   clock_pin;
  logic   clock_next;
  logic   fire;
  logic   is_req;
  logic   adv;
  logic   done;

  assign in_tready = (hs == HS_RUN) && (!out_tvalid || out_tready);
  assign fire      = in_tvalid && in_tready;
  assign is_req    = (action >= ACT_MEASURE) && (action <= ACT_LOAD_OFFSET);

  // per-item decode and transfer step
  always_comb begin
    cmd        = '0;
    cmd.status = ST_IDLE;
    phase_next = phase;
    clock_next = clock_pin;
    adv        = 1'b0;
    adv_phase  = phase;
    done       = 1'b0;

    if (fire) begin
      // requests are taken only while idle
      if (is_req) begin
        if (phase != PH_IDLE) begin
          cmd.status = ST_REJECT;
        end else begin
          unique case (action)
            ACT_MEASURE, ACT_TARE: begin
              if (stat.powered_down) begin
                cmd.status = ST_REJECT;
              end else begin
                cmd.load_req = 1'b1;
                cmd.tare     = (action == ACT_TARE);
                cmd.status   = ST_BUSY;
                adv          = 1'b1;
                adv_phase    = PH_WAIT;
              end
            end
            ACT_POWER_DOWN: begin
              cmd.set_pd = 1'b1;
              clock_next = 1'b1;
            end
            ACT_POWER_UP: begin
              cmd.clr_pd = 1'b1;
              clock_next = 1'b0;
            end
            ACT_LOAD_OFFSET: cmd.load_offset = 1'b1;
            default: ;
          endcase
        end
      end else if (phase != PH_IDLE) begin
        adv        = 1'b1;
        cmd.status = ST_BUSY;
      end

      // advance the serial transfer by one tick
      if (adv) begin
        unique case (adv_phase)
          PH_WAIT: begin
            phase_next = PH_WAIT;
            if (!dout_level) begin
              cmd.begin_conv = 1'b1;
              clock_next     = 1'b1;
              phase_next     = PH_HIGH;
            end
          end
          PH_HIGH: begin
            if (stat.tick_end) begin
              cmd.shift_in = 1'b1;
              cmd.tick_clr = 1'b1;
              clock_next   = 1'b0;
              phase_next   = PH_LOW;
            end else begin
              cmd.tick_inc = 1'b1;
            end
          end
          PH_LOW: begin
            if (!stat.tick_end) begin
              cmd.tick_inc = 1'b1;
            end else begin
              cmd.tick_clr  = 1'b1;
              cmd.pulse_inc = 1'b1;
              if (!stat.last_pulse) begin
                clock_next = 1'b1;
                phase_next = PH_HIGH;
              end else begin
                cmd.accumulate = 1'b1;
                if (stat.last_read) begin
                  phase_next = PH_IDLE;
                  done       = 1'b1;
                end else begin
                  phase_next = PH_WAIT;
                end
              end
            end
          end
          default: phase_next = PH_IDLE;
        endcase
      end

      if (done) begin
        cmd.status = ST_DONE;
      end
      cmd.out_load = !done;
    end

    cmd.div_start = (hs == HS_DIV_START);
    cmd.finish    = (hs == HS_FINISH);
    cmd.sck       = clock_next;
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      hs         <= HS_RUN;
      clock_pin  <= 1'b0;
      out_tvalid <= 1'b0;
    end else begin
      if (fire) begin
        phase     <= phase_next;
        clock_pin <= clock_next;
      end

      unique case (hs)
        HS_RUN:       if (fire && done) hs <= HS_DIV_START;
        HS_DIV_START: hs <= HS_DIV_WAIT;
        HS_DIV_WAIT:  if (stat.div_done) hs <= HS_FINISH;
        HS_FINISH:    hs <= HS_RUN;
        default:      hs <= HS_RUN;
      endcase

      if (cmd.out_load || cmd.finish) begin
        out_tvalid <= 1'b1;
      end else if (out_tready) begin
        out_tvalid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/load_cell_adc_serial_reader_core.sv =====
`default_nettype none

// Two-wire load-cell converter reader, one input item per timer tick.
// Input stream: each item carries a request code, the sampled data line
// level, a read count and an offset value; every accepted item yields
// exactly one result item (clock pin level, status, measured value).
// Configuration: plain write port, index 0 gain select, index 1 the
// number of ticks per clock pin level.
// An ordinary item gives its result in the cycle after acceptance, and
// items can be taken every cycle while the receiver keeps up.
// The tick that completes the last conversion of a request starts a
// bit-serial divider (one quotient bit per cycle); its result is presented
// from HS_FINISH, after HS_DIV_START and HS_DIV_WAIT, and no item is taken meanwhile.
// Reset (synchronous) leaves the block idle, powered up, clock pin low,
// offset zero, gain select 0 and 1000 ticks per level.
// When the receiver stalls, the result stays in the output register and
// the input is held off until it is taken or taken in the same cycle.
module load_cell_adc_serial_reader_core #(
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // action[2:0], dout_level[3], read_count[11:4], offset_load[43:12]
  input  wire logic [lcr_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // sck_level[0], status[2:1], measured_value[34:3]
  output logic [lcr_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
  input  wire logic                            cfg_we,
  input  wire logic [lcr_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [lcr_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  import lcr_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  lcr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_tvalid  (s_axis_tvalid),
    .in_tready  (s_axis_tready),
    .out_tvalid (m_axis_tvalid),
    .out_tready (m_axis_tready),
    .action     (s_axis_tdata[2:0]),
    .dout_level (s_axis_tdata[3]),
    .stat       (stat),
    .cmd        (cmd)
  );

  lcr_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .dout_level  (s_axis_tdata[3]),
    .read_count  (s_axis_tdata[11:4]),
    .offset_load (s_axis_tdata[43:12]),
    .cmd         (cmd),
    .stat        (stat),
    .out_data    (m_axis_tdata)
  );

`ifndef NO_ASSERTIONS
  // no item is taken while the divider runs
  a_div_blocks_input: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> !s_axis_tready)
    else $error("item accepted after divider start");

  a_div_done_blocks_input: assert property (@(posedge clk) disable iff (rst)
    stat.div_done |-> !s_axis_tready)
    else $error("input ready while division completes");

  // the final result finds the output register empty
  a_finish_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !m_axis_tvalid)
    else $error("final result would overwrite a pending result");

  a_finish_gives_done: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> m_axis_tvalid && (m_axis_tdata[2:1] == ST_DONE))
    else $error("final result not presented as done");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_load_cell_adc_serial_reader_core.sv =====
`timescale 1ns / 100ps

module tb_load_cell_adc_serial_reader_core;
  import lcr_pkg::*;

  localparam int SAMPLE_BITS = 24;

  // request codes the package leaves out
  localparam logic [2:0] ACT_TICK     = 3'd0;
  localparam logic [2:0] ACT_UNUSED_A = 3'd6;
  localparam logic [2:0] ACT_UNUSED_B = 3'd7;

  // gain codes the package leaves out
  localparam logic [1:0] GAIN_A128  = 2'd0;
  localparam logic [1:0] GAIN_SPARE = 2'd3;

  typedef enum logic [1:0] {PH_IDLE, PH_WAIT, PH_HIGH, PH_LOW} xfer_phase_t;
  typedef enum logic [1:0] {RX_STEADY, RX_COIN, RX_PERIODIC, RX_CHOPPY} rx_mode_t;

  typedef struct {
    logic          pin;
    status_t       status;
    logic [31:0]   value;
  } reader_out_t;

  logic                   clk;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  // action[2:0], dout_level[3], read_count[11:4], offset_load[43:12]
  logic [IN_DATA_W-1:0]   s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  // sck_level[0], status[2:1], measured_value[34:3]
  logic [OUT_DATA_W-1:0]  m_axis_tdata;
  logic                   cfg_we;
  logic [CFG_ADDR_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  load_cell_adc_serial_reader_core #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  // reader model state
  xfer_phase_t             rd_phase;
  logic [4:0]              rd_pulse;
  logic [15:0]             rd_ticks;
  logic [SAMPLE_BITS-1:0]  rd_shift;
  logic [31:0]             rd_sum;
  logic [7:0]              rd_left;
  logic [7:0]              rd_total;
  logic [31:0]             rd_offset;
  logic                    rd_tare;
  logic                    rd_pd;
  logic                    rd_pin;
  logic [1:0]              cfg_gain;
  logic [15:0]             cfg_half;

  reader_out_t             reader_outputs[$];
  logic [SAMPLE_BITS-1:0]  planned_words[$];
  logic [SAMPLE_BITS-1:0]  cur_word;

  int unsigned item_total;
  int unsigned fail_count;
  int          burst_left;
  bit          item_offered;

  rx_mode_t    rx_mode;
  int          rx_left;
  int unsigned rx_count;

  reader_out_t want_out;

  always #6 clk = ~clk;

  // one tick of an active transfer, returns 1 when the request completes
  function automatic bit step_transfer(input logic dout);
    logic [15:0] hp;
    logic [4:0]  extra;
    logic [31:0] word_ext;
    hp = (cfg_half == 16'd0) ? 16'd1 : cfg_half;
    extra = (cfg_gain == GAIN_A64) ? 5'd3 : (cfg_gain == GAIN_B32) ? 5'd2 : 5'd1;
    step_transfer = 1'b0;
    case (rd_phase)
      PH_WAIT: begin
        if (!dout) begin
          rd_pulse = '0;
          rd_ticks = '0;
          rd_shift = '0;
          rd_pin   = 1'b1;
          rd_phase = PH_HIGH;
        end
      end
      PH_HIGH: begin
        rd_ticks = rd_ticks + 16'd1;
        if (rd_ticks >= hp || rd_ticks == 16'd0) begin
          if (rd_pulse < SAMPLE_BITS) rd_shift = {rd_shift[SAMPLE_BITS-2:0], dout};
          rd_pin   = 1'b0;
          rd_ticks = '0;
          rd_phase = PH_LOW;
        end
      end
      PH_LOW: begin
        rd_ticks = rd_ticks + 16'd1;
        if (rd_ticks >= hp || rd_ticks == 16'd0) begin
          rd_ticks = '0;
          rd_pulse = rd_pulse + 5'd1;
          if (rd_pulse < SAMPLE_BITS + extra) begin
            rd_pin   = 1'b1;
            rd_phase = PH_HIGH;
          end else begin
            // sign-extend the finished word into the running sum
            word_ext = {{(32-SAMPLE_BITS){rd_shift[SAMPLE_BITS-1]}}, rd_shift};
            rd_sum   = rd_sum + word_ext;
            rd_left  = rd_left - 8'd1;
            if (rd_left != 8'd0) begin
              rd_phase = PH_WAIT;
            end else begin
              rd_phase = PH_IDLE;
              step_transfer = 1'b1;
            end
          end
        end
      end
      default: rd_phase = PH_IDLE;
    endcase
  endfunction

  // work out the result item of one accepted input item
  function automatic void predict_reading(input logic [2:0] act, input logic dout,
                                          input logic [7:0] cnt, input logic [31:0] load);
    reader_out_t r;
    longint      tot;
    longint      avg;
    longint      diff;
    bit          fin;
    r.status = ST_IDLE;
    r.value  = '0;
    fin      = 1'b0;
    if (act >= ACT_MEASURE && act <= ACT_LOAD_OFFSET) begin
      if (rd_phase != PH_IDLE) begin
        r.status = ST_REJECT;
      end else if (act == ACT_MEASURE || act == ACT_TARE) begin
        if (rd_pd) begin
          r.status = ST_REJECT;
        end else begin
          rd_total = (cnt == 8'd0) ? 8'd1 : cnt;
          rd_left  = rd_total;
          rd_sum   = '0;
          rd_tare  = (act == ACT_TARE);
          rd_phase = PH_WAIT;
          fin      = step_transfer(dout);
          r.status = fin ? ST_DONE : ST_BUSY;
        end
      end else if (act == ACT_POWER_DOWN) begin
        rd_pd  = 1'b1;
        rd_pin = 1'b1;
      end else if (act == ACT_POWER_UP) begin
        rd_pd  = 1'b0;
        rd_pin = 1'b0;
      end else begin
        rd_offset = load;
      end
    end else if (rd_phase != PH_IDLE) begin
      fin      = step_transfer(dout);
      r.status = fin ? ST_DONE : ST_BUSY;
    end

    // average with truncation toward zero, then tare or offset and clamp
    if (fin) begin
      tot = (rd_total == 8'd0) ? 1 : longint'(rd_total);
      avg = longint'(signed'(rd_sum)) / tot;
      if (rd_tare) begin
        rd_offset = avg[31:0];
        rd_tare   = 1'b0;
      end else begin
        diff = avg - longint'(signed'(rd_offset));
        if (diff > longint'(SAT_MAX)) diff = longint'(SAT_MAX);
        if (diff < longint'(SAT_MIN)) diff = longint'(SAT_MIN);
        r.value = diff[31:0];
      end
    end
    r.pin = rd_pin;
    reader_outputs.push_back(r);
  endfunction

  // data line level for the next tick, following the word being sent
  function automatic logic tick_dout(input bit waiting);
    logic [15:0] hp;
    logic [15:0] next_ticks;
    hp = (cfg_half == 16'd0) ? 16'd1 : cfg_half;
    next_ticks = rd_ticks + 16'd1;
    if (waiting) begin
      if ($urandom_range(0, 2) != 0) return 1'b1;
      if (planned_words.size() != 0) cur_word = planned_words.pop_front();
      else if ($urandom_range(0, 7) == 0)
        cur_word = $urandom_range(0, 1) ? {1'b0, {(SAMPLE_BITS-1){1'b1}}}
                                        : {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      else cur_word = SAMPLE_BITS'($urandom);
      return 1'b0;
    end
    if (rd_phase == PH_HIGH && (next_ticks >= hp || next_ticks == 16'd0) &&
        rd_pulse < SAMPLE_BITS)
      return cur_word[SAMPLE_BITS-1-rd_pulse];
    return 1'($urandom);
  endfunction

  function automatic logic [2:0] pick_tick_action();
    if ($urandom_range(0, 7) != 0) return ACT_TICK;
    return $urandom_range(0, 1) ? ACT_UNUSED_A : ACT_UNUSED_B;
  endfunction

  // offer one item in bursts with random gaps, returns at a falling edge
  task automatic send_item(input logic [2:0] act, input logic dout,
                           input logic [7:0] cnt, input logic [31:0] load);
    int gap;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                               : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap != 0 && item_offered) begin
        s_axis_tvalid <= 1'b0;
        item_offered = 1'b0;
      end
      repeat (gap) @(negedge clk);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_DATA_W-44){1'b0}}, load, cnt, dout, act};
    item_offered = 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    item_total++;
    predict_reading(act, dout, cnt, load);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    if (item_offered) begin
      s_axis_tvalid <= 1'b0;
      item_offered = 1'b0;
    end
    while (reader_outputs.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_GAIN_SELECT) cfg_gain = val[1:0];
    else cfg_half = val;
    @(negedge clk);
  endtask

  // start or tare request, then ticks until the model goes idle again
  task automatic run_request(input logic [2:0] act, input logic [7:0] cnt, input int noise_pct);
    logic dout;
    if (rd_phase == PH_IDLE && !rd_pd) dout = tick_dout(1'b1);
    else dout = 1'($urandom);
    send_item(act, dout, cnt, $urandom);
    while (rd_phase != PH_IDLE) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        send_item(3'($urandom_range(ACT_MEASURE, ACT_LOAD_OFFSET)), 1'($urandom),
                  8'($urandom), $urandom);
      end else begin
        dout = tick_dout(rd_phase == PH_WAIT);
        send_item(pick_tick_action(), dout, 8'($urandom), $urandom);
      end
    end
  endtask

  // power control, offset loads and rejected starts while idle
  task automatic test_idle_controls();
    send_item(ACT_TICK, 1'b0, 8'h00, 32'h0000_0000);
    send_item(ACT_UNUSED_A, 1'b1, 8'hFF, 32'hFFFF_FFFF);
    send_item(ACT_UNUSED_B, 1'b0, 8'h55, 32'hA5A5_A5A5);
    send_item(ACT_POWER_DOWN, 1'b1, 8'h01, 32'h0);
    send_item(ACT_MEASURE, 1'b0, 8'h01, 32'h0);
    send_item(ACT_TARE, 1'b0, 8'h03, 32'h0);
    send_item(ACT_TICK, 1'b0, 8'h00, 32'h0);
    send_item(ACT_POWER_UP, 1'b0, 8'h00, 32'h0);
    send_item(ACT_LOAD_OFFSET, 1'b1, 8'h00, 32'h8000_0000);
    send_item(ACT_LOAD_OFFSET, 1'b0, 8'hFF, 32'h7FFF_FFFF);
    // widest half period, only idle traffic since a pulse would last too long
    write_reg(REG_HALF_PERIOD, 16'hFFFF);
    write_reg(REG_GAIN_SELECT, CFG_DATA_W'(GAIN_SPARE));
    send_item(ACT_TICK, 1'b1, 8'h00, 32'h0);
    send_item(ACT_POWER_DOWN, 1'b0, 8'h00, 32'h0);
    send_item(ACT_POWER_UP, 1'b0, 8'h00, 32'h0);
  endtask

  // one read per gain code, zero half period taken as one
  task automatic test_single_reads();
    write_reg(REG_HALF_PERIOD, 16'd0);
    send_item(ACT_LOAD_OFFSET, 1'b0, 8'h00, 32'h0);
    write_reg(REG_GAIN_SELECT, CFG_DATA_W'(GAIN_A128));
    planned_words.push_back({1'b0, {(SAMPLE_BITS-1){1'b1}}});
    run_request(ACT_MEASURE, 8'd1, 0);
    write_reg(REG_GAIN_SELECT, CFG_DATA_W'(GAIN_A64));
    planned_words.push_back({1'b1, {(SAMPLE_BITS-1){1'b0}}});
    run_request(ACT_MEASURE, 8'd0, 5);
    write_reg(REG_GAIN_SELECT, CFG_DATA_W'(GAIN_B32));
    planned_words.push_back('0);
    run_request(ACT_MEASURE, 8'd1, 5);
    write_reg(REG_GAIN_SELECT, CFG_DATA_W'(GAIN_SPARE));
    planned_words.push_back('1);
    run_request(ACT_MEASURE, 8'd1, 5);
  endtask

  // tare sets the offset, then a negative average truncates toward zero
  task automatic test_tare_then_measure();
    write_reg(REG_GAIN_SELECT, CFG_DATA_W'(GAIN_A128));
    planned_words.push_back(SAMPLE_BITS'(100));
    planned_words.push_back(SAMPLE_BITS'(200));
    planned_words.push_back(SAMPLE_BITS'(301));
    run_request(ACT_TARE, 8'd3, 10);
    planned_words.push_back('1);
    planned_words.push_back('0);
    run_request(ACT_MEASURE, 8'd2, 10);
  endtask

  // offset far enough to clamp the result at both ends
  task automatic test_saturation();
    send_item(ACT_LOAD_OFFSET, 1'b0, 8'h00, 32'h8000_0000);
    planned_words.push_back({1'b0, {(SAMPLE_BITS-1){1'b1}}});
    run_request(ACT_MEASURE, 8'd1, 0);
    send_item(ACT_LOAD_OFFSET, 1'b0, 8'h00, 32'h7FFF_FFFF);
    planned_words.push_back({1'b1, {(SAMPLE_BITS-1){1'b0}}});
    run_request(ACT_MEASURE, 8'd1, 0);
  endtask

  // longest pulse train over a longer half period
  task automatic test_long_runs();
    write_reg(REG_HALF_PERIOD, 16'd2);
    write_reg(REG_GAIN_SELECT, CFG_DATA_W'(GAIN_A64));
    send_item(ACT_LOAD_OFFSET, 1'b0, 8'h00, $urandom);
    run_request(ACT_MEASURE, 8'd1, 2);
  endtask

  task automatic test_random_traffic();
    int unsigned items_goal;
    int          pick;
    logic [7:0]  cnt;
    items_goal = item_total + 100;
    write_reg(REG_HALF_PERIOD, 16'd1);
    while (item_total < items_goal) begin
      // new register settings between requests
      if ($urandom_range(0, 9) == 0) begin
        write_reg(REG_GAIN_SELECT, CFG_DATA_W'($urandom_range(0, 3)));
        pick = $urandom_range(0, 19);
        if (pick == 0) write_reg(REG_HALF_PERIOD, 16'd0);
        else if (pick < 4) write_reg(REG_HALF_PERIOD, 16'd3);
        else write_reg(REG_HALF_PERIOD, 16'($urandom_range(1, 2)));
      end
      pick = $urandom_range(0, 49);
      if (pick == 0) cnt = 8'd0;
      else if (pick < 8) cnt = 8'($urandom_range(2, 3));
      else cnt = 8'd1;
      pick = $urandom_range(0, 99);
      if (pick < 40) run_request(ACT_MEASURE, cnt, 5);
      else if (pick < 55) run_request(ACT_TARE, cnt, 5);
      else if (pick < 62) send_item(rd_pd ? ACT_POWER_UP : ACT_POWER_DOWN, 1'($urandom),
                                    8'($urandom), $urandom);
      else if (pick < 64) send_item(ACT_POWER_DOWN, 1'($urandom), 8'($urandom), $urandom);
      else if (pick < 74) send_item(ACT_LOAD_OFFSET, 1'($urandom), 8'($urandom), $urandom);
      else repeat ($urandom_range(1, 4))
        send_item(pick_tick_action(), 1'($urandom), 8'($urandom), $urandom);
    end
  endtask

  // receiver stall pattern
  always @(negedge clk) begin
    if (rx_left <= 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(16, 200);
    end
    rx_left--;
    rx_count++;
    case (rx_mode)
      RX_STEADY:   m_axis_tready <= 1'b1;
      RX_COIN:     m_axis_tready <= 1'($urandom);
      RX_PERIODIC: m_axis_tready <= (rx_count % 5 != 0);
      default:     m_axis_tready <= (rx_count[2:0] < 3'd3);
    endcase
  end

  // compare each result item with the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (reader_outputs.size() == 0) begin
        $error("result item with no prediction pending: %h", m_axis_tdata);
        fail_count++;
      end else begin
        want_out = reader_outputs.pop_front();
        if (m_axis_tdata[0] !== want_out.pin) begin
          $error("sck_level expected %0d got %0d", want_out.pin, m_axis_tdata[0]);
          fail_count++;
        end
        if (m_axis_tdata[2:1] !== want_out.status) begin
          $error("status expected %0d got %0d", want_out.status, m_axis_tdata[2:1]);
          fail_count++;
        end
        if (m_axis_tdata[34:3] !== want_out.value) begin
          $error("measured_value expected %0d got %0d",
                 signed'(want_out.value), signed'(m_axis_tdata[34:3]));
          fail_count++;
        end
      end
    end
  end

  initial begin
    #40_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    clk           = 1'b0;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_we        = 1'b0;
    cfg_addr      = '0;
    cfg_wdata     = '0;
    item_total    = 0;
    fail_count    = 0;
    burst_left    = 0;
    item_offered  = 1'b0;
    rx_left       = 0;
    rx_count      = 0;
    rx_mode       = RX_STEADY;
    cur_word      = '0;
    // model state after reset
    rd_phase  = PH_IDLE;
    rd_pulse  = '0;
    rd_ticks  = '0;
    rd_shift  = '0;
    rd_sum    = '0;
    rd_left   = '0;
    rd_total  = '0;
    rd_offset = '0;
    rd_tare   = 1'b0;
    rd_pd     = 1'b0;
    rd_pin    = 1'b0;
    cfg_gain  = GAIN_A128;
    cfg_half  = 16'd1000;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_idle_controls();
    test_single_reads();
    test_tare_then_measure();
    test_saturation();
    test_long_runs();
    test_random_traffic();

    wait_drained();
    repeat (64) @(negedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
